[rtl/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Pool size, field widths, operation and status codes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int unsigned PAGES  = 1024;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned REF_W  = 8;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned PAGE_W = $clog2(PAGES);
  localparam int unsigned FREE_W = $clog2(PAGES + 1);

  localparam logic [REF_W-1:0] REF_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 3'd0,
    FN_FREE  = 3'd1,
    FN_ADD   = 3'd2,
    FN_DROP  = 3'd3,
    FN_COW   = 3'd4,
    FN_READ  = 3'd5
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_SOLE      = 3'd3,
    ST_SATURATED = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic clr_we;
    logic accept;
    logic pop;
    logic commit;
  } pfa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic alloc_go;
  } pfa_sts_t;

endpackage

[rtl/page_frame_allocator_refcount.sv]
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount: physical page pool with reference counts
// Usage:
//   Requests enter on the in channel (func_i, page_index_i under valid/ready);
//   each produces exactly one item on the out channel (page_out_o,
//   ref_count_o, page_freed_o, status_o under valid/ready).
//   Operations: allocate (pop the free stack), free (push), add reference,
//   drop reference (push when the count reaches zero), copy-on-write release
//   and read count. Errors are reported in status_o, never fatal.
// Sequencing:
//   Allocate with pages left reads the stack top at accept, then the count
//   of the popped page, then commits; every other request reads the count
//   at accept, then commits. Requests run one at a time: a new request is
//   accepted only after the last one has committed.
// Reset:
//   Stack slots never written since reset read back their reset page. The
//   count memory is swept clear, all 1024 entries, with in_ready_o held low.
// Back-pressure:
//   A result waits in the output register while out_ready_i is low; the next
//   request is still accepted and runs up to its commit, then holds until the
//   output register frees up.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount
  import pfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [IDX_W-1:0]  page_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IDX_W-1:0]  page_out_o,
  output logic [REF_W-1:0]  ref_count_o,
  output logic              page_freed_o,
  output logic [STAT_W-1:0] status_o
);

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  // sequencer: clear sweep, accept, pop, commit
  pfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // memories, stack pointer and result registers
  pfa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .page_index_i (page_index_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .page_out_o   (page_out_o),
    .ref_count_o  (ref_count_o),
    .page_freed_o (page_freed_o),
    .status_o     (status_o)
  );

endmodule

[rtl/pfa_ram.sv]
// ----------------------------------------------------------------------------
// pfa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pfa_ctrl.sv]
// ----------------------------------------------------------------------------
// pfa_ctrl: request sequencer of the page frame allocator
// Runs the count clearing sweep, accepts items, steps pops and commits
// results into the output register.
// ----------------------------------------------------------------------------
module pfa_ctrl
  import pfa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  pfa_sts_t sts_i,
  output pfa_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.alloc_go ? S_POP : S_EXEC;
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/pfa_dp.sv]
// ----------------------------------------------------------------------------
// pfa_dp: datapath of the page frame allocator
// Free stack and count memories, stack pointer, request and result registers.
// ----------------------------------------------------------------------------
module pfa_dp
  import pfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [IDX_W-1:0]  page_index_i,
  input  pfa_cmd_t          cmd_i,
  output pfa_sts_t          sts_o,
  output logic [IDX_W-1:0]  page_out_o,
  output logic [REF_W-1:0]  ref_count_o,
  output logic              page_freed_o,
  output logic [STAT_W-1:0] status_o
);

  // control state
  logic [PAGE_W-1:0] clr_q;
  logic [FREE_W-1:0] free_count_q;
  logic [FREE_W-1:0] wm_q;  // lowest stack slot written since reset

  // request registers
  func_e             func_q;
  logic [IDX_W-1:0]  page_q;
  logic              in_range_q;
  logic              empty_q;
  logic [IDX_W-1:0]  popped_q;

  // result registers
  logic [IDX_W-1:0]  page_out_q;
  logic [REF_W-1:0]  ref_count_q;
  logic              page_freed_q;
  status_e           status_q;

  func_e             in_func;
  logic [FREE_W-1:0] top_full;
  logic [PAGE_W-1:0] top_idx;
  logic [PAGE_W-1:0] rst_page;
  logic              stale;
  logic [IDX_W-1:0]  popped;
  logic [IDX_W-1:0]  stk_rdata;
  logic [REF_W-1:0]  cnt_rdata;
  logic              full;

  logic [IDX_W-1:0]  r_page;
  logic [REF_W-1:0]  r_cnt;
  logic              r_freed;
  status_e           r_stat;
  logic              push;
  logic              cnt_wr;

  logic              stk_we;
  logic              cnt_we;
  logic [PAGE_W-1:0] cnt_waddr;
  logic [REF_W-1:0]  cnt_wdata;
  logic              cnt_re;
  logic [PAGE_W-1:0] cnt_raddr;

  assign in_func  = func_e'(func_i);
  assign top_full = free_count_q - FREE_W'(1);
  assign top_idx  = top_full[PAGE_W-1:0];
  assign rst_page = PAGE_W'(PAGES - 1) - top_idx;
  assign stale    = FREE_W'(top_idx) < wm_q;
  assign popped   = stale ? IDX_W'(rst_page) : stk_rdata;
  assign full     = free_count_q == FREE_W'(PAGES);

  assign sts_o.alloc_go = (in_func == FN_ALLOC) && (free_count_q != '0);
  assign sts_o.clr_last = clr_q == PAGE_W'(PAGES - 1);

  // result and side effects of the current request
  always_comb begin
    r_page  = page_q;
    r_cnt   = cnt_rdata;
    r_freed = 1'b0;
    r_stat  = ST_OK;
    push    = 1'b0;
    cnt_wr  = 1'b0;
    priority if (func_q == FN_ALLOC) begin
      if (empty_q) begin
        r_page = '0;
        r_cnt  = '0;
        r_stat = ST_EMPTY;
      end else begin
        r_page = popped_q;
      end
    end else if (!in_range_q) begin
      r_cnt = '0;
    end else begin
      cnt_wr = 1'b1;
      unique case (func_q)
        FN_FREE: begin
          if (full) begin
            r_stat = ST_FULL;
          end else begin
            push    = 1'b1;
            r_freed = 1'b1;
          end
        end
        FN_ADD: begin
          if (cnt_rdata == REF_MAX) begin
            r_stat = ST_SATURATED;
          end else begin
            r_cnt = cnt_rdata + REF_W'(1);
          end
        end
        FN_DROP: begin
          if (cnt_rdata == '0) begin
            r_stat = ST_UNDERFLOW;
          end else begin
            r_cnt = cnt_rdata - REF_W'(1);
            if (cnt_rdata == REF_W'(1)) begin
              if (full) begin
                r_stat = ST_FULL;
              end else begin
                push    = 1'b1;
                r_freed = 1'b1;
              end
            end
          end
        end
        FN_COW: begin
          if (cnt_rdata == '0) begin
            r_stat = ST_UNDERFLOW;
          end else if (cnt_rdata == REF_W'(1)) begin
            r_stat = ST_SOLE;
          end else begin
            r_cnt = cnt_rdata - REF_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stk_we    = cmd_i.commit && push;
  assign cnt_we    = cmd_i.clr_we || (cmd_i.commit && cnt_wr);
  assign cnt_waddr = cmd_i.clr_we ? clr_q : PAGE_W'(page_q);
  assign cnt_wdata = cmd_i.clr_we ? '0 : r_cnt;
  assign cnt_re    = cmd_i.accept || cmd_i.pop;
  assign cnt_raddr = cmd_i.pop ? PAGE_W'(popped) : PAGE_W'(page_index_i);

  pfa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (PAGES)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (free_count_q[PAGE_W-1:0]),
    .wdata_i (page_q),
    .re_i    (cmd_i.accept),
    .raddr_i (top_idx),
    .rdata_o (stk_rdata)
  );

  pfa_ram #(
    .WIDTH (REF_W),
    .DEPTH (PAGES)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      free_count_q <= FREE_W'(PAGES);
      wm_q         <= FREE_W'(PAGES);
    end else begin
      if (cmd_i.clr_we) begin
        clr_q <= clr_q + PAGE_W'(1);
      end
      if (cmd_i.pop) begin
        free_count_q <= top_full;
      end else if (stk_we) begin
        free_count_q <= free_count_q + FREE_W'(1);
        if (free_count_q < wm_q) begin
          wm_q <= free_count_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q     <= in_func;
      page_q     <= page_index_i;
      in_range_q <= 32'(page_index_i) < 32'(PAGES);
      empty_q    <= free_count_q == '0;
    end
    if (cmd_i.pop) begin
      popped_q <= popped;
    end
    if (cmd_i.commit) begin
      page_out_q   <= r_page;
      ref_count_q  <= r_cnt;
      page_freed_q <= r_freed;
      status_q     <= r_stat;
    end
  end

  assign page_out_o   = page_out_q;
  assign ref_count_o  = ref_count_q;
  assign page_freed_o = page_freed_q;
  assign status_o     = status_q;

endmodule

[rtl/pfa_checker.sv]
// ----------------------------------------------------------------------------
// pfa_checker: port-level checks of the page frame allocator
// Watches the top level's ports; attached to it by the bind below.
// ----------------------------------------------------------------------------
module pfa_checker
  import pfa_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [FUNC_W-1:0] func_i,
  input logic [IDX_W-1:0]  page_index_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [IDX_W-1:0]  page_out_o,
  input logic [REF_W-1:0]  ref_count_o,
  input logic              page_freed_o,
  input logic [STAT_W-1:0] status_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(page_out_o)
      && $stable(ref_count_o) && $stable(status_o) && $stable(page_freed_o))
    else $error("stalled result changed");

  // one request in flight
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted back to back");

  // empty pool reports nothing
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> page_out_o == '0 && ref_count_o == '0
      && !page_freed_o)
    else $error("empty result carries data");

  // a freed page always means success
  a_freed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && page_freed_o |-> status_o == ST_OK)
    else $error("page freed with error status");

  // error codes match the reported count
  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != ST_SATURATED || ref_count_o == REF_MAX)
      && (status_o != ST_SOLE || ref_count_o == REF_W'(1))
      && (status_o != ST_UNDERFLOW || ref_count_o == '0))
    else $error("count inconsistent with status");

endmodule

bind page_frame_allocator_refcount pfa_checker u_pfa_checker (.*);

[dv/tb_page_frame_allocator_refcount.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_frame_allocator_refcount: self-checking bench for the page allocator
// Drives allocate/free/reference requests through the in channel. A
// scoreboard class mirrors the LIFO free list and the per-page counts and
// checks every item on the out channel in order. Stimulus covers directed
// corner cases, lifecycle sequences on allocated pages, random noise, a full
// drain of the pool and a saturated count. Both channels are throttled at
// random, and a long output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_page_frame_allocator_refcount
  import pfa_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned MAX_PRINTS  = 40;

  // Func codes without a name in the package; the block treats them as reads.
  localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

  // One expected item on the out channel.
  typedef struct packed {
    logic [IDX_W-1:0] page;
    logic [REF_W-1:0] refs;
    logic             freed;
    status_e          status;
  } pfa_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a mirror of the free stack and the count table, plus the
  // queue of results still owed by the block.
  // --------------------------------------------------------------------------
  class pfa_scoreboard;
    logic [IDX_W-1:0]  free_pages [PAGES];
    logic [FREE_W-1:0] depth;
    logic [REF_W-1:0]  counts [PAGES];
    pfa_result_t       pending [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       status_hits [6];

    // Load the post-reset picture: every page free, page 0 on top.
    function new();
      for (int k = 0; k < PAGES; k++) begin
        free_pages[k] = IDX_W'(PAGES - 1 - k);
        counts[k]     = '0;
      end
      depth = FREE_W'(PAGES);
      for (int k = 0; k < 6; k++) status_hits[k] = 0;
      errors  = 0;
      checked = 0;
    endfunction

    // Push onto the mirror stack; refuse when it already holds every page.
    function bit push_page(logic [IDX_W-1:0] pg);
      if (depth >= PAGES) return 1'b0;
      free_pages[depth] = pg;
      depth++;
      return 1'b1;
    endfunction

    // Apply one accepted request to the mirror and queue the item it owes.
    function pfa_result_t note_request(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] pg);
      pfa_result_t      r;
      logic [REF_W-1:0] c;
      r.page   = pg;
      r.refs   = '0;
      r.freed  = 1'b0;
      r.status = ST_OK;
      if (fn == FN_ALLOC) begin
        if (depth == 0) begin
          r.page   = '0;
          r.status = ST_EMPTY;
        end else begin
          depth--;
          r.page = free_pages[depth];
          r.refs = counts[r.page];
        end
      end else if (pg < PAGES) begin
        c = counts[pg];
        case (fn)
          FN_FREE: begin
            if (push_page(pg)) r.freed = 1'b1;
            else r.status = ST_FULL;
          end
          FN_ADD: begin
            if (c == REF_MAX) r.status = ST_SATURATED;
            else c++;
          end
          FN_DROP: begin
            if (c == 0) begin
              r.status = ST_UNDERFLOW;
            end else begin
              c--;
              // count now zero: push the page back, or report a full list
              if (c == 0) begin
                if (push_page(pg)) r.freed = 1'b1;
                else r.status = ST_FULL;
              end
            end
          end
          FN_COW: begin
            if (c == 0) r.status = ST_UNDERFLOW;
            else if (c == 1) r.status = ST_SOLE;
            else c--;
          end
          default: ;
        endcase
        counts[pg] = c;
        r.refs     = c;
      end
      pending.push_back(r);
      return r;
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("[%0t] MISMATCH item %0d: %s got %0d want %0d",
                 $realtime, checked, what, got, want);
    endtask

    // Compare one accepted out item against the oldest expectation.
    task check_result(logic [IDX_W-1:0] page, logic [REF_W-1:0] refs, logic freed,
                      logic [STAT_W-1:0] status);
      pfa_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("item with nothing outstanding, page_out", page, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      status_hits[want.status]++;
      if (page !== want.page) report_mismatch("page_out", page, want.page);
      if (refs !== want.refs) report_mismatch("ref_count", refs, want.refs);
      if (freed !== want.freed) report_mismatch("page_freed", freed, want.freed);
      if (status !== want.status) report_mismatch("status", status, want.status);
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i;
  logic [IDX_W-1:0]  page_index_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [IDX_W-1:0]  page_out_o;
  logic [REF_W-1:0]  ref_count_o;
  logic              page_freed_o;
  logic [STAT_W-1:0] status_o;

  pfa_scoreboard sb = new();
  pfa_result_t   last_result;
  logic [IDX_W-1:0] owned_pages [$];   // pages the stimulus treats as still mapped
  int unsigned   items_sent   = 0;
  int unsigned   snd_idle_pct = 0;
  int unsigned   rcv_idle_pct = 0;
  bit            hold_off_req = 1'b0;
  int unsigned   hold_left    = 0;
  int unsigned   cycle_count  = 0;

  page_frame_allocator_refcount uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .page_index_i (page_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .page_out_o   (page_out_o),
    .ref_count_o  (ref_count_o),
    .page_freed_o (page_freed_o),
    .status_o     (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Bound the run; the slowest legal run including the count-clearing sweep
  // is far below this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding",
               cycle_count, sb.pending.size());
      $display("page_frame_allocator_refcount verification failed");
      $finish;
    end
  end

  // Offer one item: idle for a random gap, raise valid with the payload,
  // hold it until the block takes it, then record it in the scoreboard.
  // Valid stays high into the next item when there is no gap.
  task automatic offer(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] pg);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= fn;
    page_index_i <= pg;
    do @(posedge clk_i); while (!in_ready_o);
    last_result = sb.note_request(fn, pg);
    items_sent++;
  endtask

  // Random traffic: mostly well-formed page lifecycles (allocate, take a
  // reference, share, release), some operations on pages still held, and
  // the rest pure noise across every func code and page.
  task automatic run_random(input int unsigned n);
    int unsigned      stop_at;
    logic [IDX_W-1:0] pg;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          offer(FN_ALLOC, IDX_W'($urandom));
          pg = last_result.page;
          offer(FN_ADD, pg);
          repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 4))
              0, 1:    offer(FN_ADD, pg);
              2:       offer(FN_COW, pg);
              3:       offer(FN_READ, pg);
              default: offer(FN_DROP, pg);
            endcase
          end
          // either release every reference or keep the page mapped for later
          if ($urandom_range(0, 1) == 0) begin
            repeat (8) if (sb.counts[pg] != 0) offer(FN_DROP, pg);
          end else begin
            if (owned_pages.size() >= 64) owned_pages.delete(0);
            owned_pages.push_back(pg);
          end
        end
        2: begin
          if (owned_pages.size() != 0)
            pg = owned_pages[$urandom_range(0, owned_pages.size() - 1)];
          else
            pg = IDX_W'($urandom);
          case ($urandom_range(0, 5))
            0:       offer(FN_ADD, pg);
            1:       offer(FN_DROP, pg);
            2:       offer(FN_COW, pg);
            3:       offer(FN_READ, pg);
            4:       offer(FN_FREE, pg);
            default: offer(FN_DROP, pg);
          endcase
        end
        default: offer(FUNC_W'($urandom_range(0, 7)), IDX_W'($urandom));
      endcase
    end
  endtask

  // Receiver: take items, check them, and throttle ready. A pending hold-off
  // request turns into a long stall counted here so the block backs up.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(page_out_o, ref_count_o, page_freed_o, status_o);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    logic [IDX_W-1:0] sat_page;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = '0;
    page_index_i = '0;

    // Phase one: sender mostly busy, receiver mostly stalling.
    snd_idle_pct = 13;
    rcv_idle_pct = 85;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners. The stack starts full, so pushes are refused at first.
    offer(FN_READ, 10'd0);          // count of the lowest page after reset
    offer(FN_READ, 10'd1023);       // and of the highest
    offer(FN_FREE, 10'd1023);       // free list already full
    offer(FN_ADD, 10'd1023);
    offer(FN_DROP, 10'd1023);       // count hits zero, push refused as full
    offer(FN_DROP, 10'd1023);       // underflow
    offer(FN_COW, 10'd1023);        // underflow on cow release
    offer(FN_ALLOC, 10'd1023);      // pops page 0, index ignored
    offer(FN_ADD, 10'd0);
    offer(FN_COW, 10'd0);           // sole owner keeps the page
    offer(FN_ADD, 10'd0);
    offer(FN_COW, 10'd0);           // shared: drop one reference
    offer(FN_DROP, 10'd0);          // last reference: page goes back
    offer(FN_ALLOC, 10'd0);         // LIFO hands page 0 out again
    offer(FN_ALLOC, 10'd0);
    offer(FN_FREE, last_result.page);
    offer(FN_FREE, last_result.page);  // double free lands twice on the stack
    offer(FN_ALLOC, 10'd0);
    offer(FN_ALLOC, 10'd0);         // same page handed out a second time
    offer(FN_RSVD6, 10'd682);       // spare codes read the count
    offer(FN_RSVD7, 10'd341);
    offer(FN_FREE, 10'd0);          // free ignores the count entirely

    run_random(50);

    // Phase two: sender mostly idle, receiver mostly ready.
    snd_idle_pct = 85;
    rcv_idle_pct = 13;

    // Drain the pool completely, then hit it while empty.
    while (sb.depth != 0) offer(FN_ALLOC, IDX_W'($urandom));
    repeat (3) offer(FN_ALLOC, IDX_W'($urandom));

    // Drive one count to the ceiling and past it.
    sat_page = IDX_W'($urandom_range(0, 1023));
    while (sb.counts[sat_page] != REF_MAX) offer(FN_ADD, sat_page);
    repeat (2) offer(FN_ADD, sat_page);
    offer(FN_COW, sat_page);
    offer(FN_DROP, sat_page);
    offer(FN_READ, sat_page);

    run_random(30);

    // Phase three: no throttling, except one long output stall up front
    // while the sender keeps offering.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_off_req = 1'b1;
    run_random(50);
    in_valid_i <= 1'b0;

    // Wait for the outstanding items, then give stray items a chance to show.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("ran %0d requests, checked %0d items: ok %0d, empty %0d, underflow %0d,",
             items_sent, sb.checked, sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY],
             sb.status_hits[ST_UNDERFLOW]);
    $display("  sole owner %0d, saturated %0d, list full %0d; pool drained, long stall",
             sb.status_hits[ST_SOLE], sb.status_hits[ST_SATURATED],
             sb.status_hits[ST_FULL]);
    if (sb.errors == 0) begin
      $display("page_frame_allocator_refcount verification clean");
    end else begin
      $display("page_frame_allocator_refcount verification failed");
    end
    $finish;
  end

endmodule
